/* hw/rtl/bnc_pkg.sv */
// Package of the bracket nesting checker: state type, result codes,
// character decode and mismatch weights.
// No dependencies.
package bnc_pkg;

    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    localparam logic [1:0] LK_OPEN     = 2'd0;
    localparam logic [1:0] LK_CORRUPT  = 2'd1;
    localparam logic [1:0] LK_OVERFLOW = 2'd2;

    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [14:0] WEIGHT_PAREN  = 15'd3;
    localparam logic [14:0] WEIGHT_SQUARE = 15'd57;
    localparam logic [14:0] WEIGHT_CURLY  = 15'd1197;
    localparam logic [14:0] WEIGHT_ANGLE  = 15'd25137;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_FINISH,
        S_FOLD,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } t_sym_info;

    typedef struct packed {
        logic clear;
        logic step;
    } t_fold_ctl;

    function automatic t_sym_info decode_symbol(input logic [7:0] sym);
        t_sym_info info;
        info = '0;
        case (sym)
            CH_OPEN_PAREN: begin
                info.is_open = 1'b1;
                info.kind    = KIND_PAREN;
            end
            CH_OPEN_SQUARE: begin
                info.is_open = 1'b1;
                info.kind    = KIND_SQUARE;
            end
            CH_OPEN_CURLY: begin
                info.is_open = 1'b1;
                info.kind    = KIND_CURLY;
            end
            CH_OPEN_ANGLE: begin
                info.is_open = 1'b1;
                info.kind    = KIND_ANGLE;
            end
            CH_CLOSE_PAREN: begin
                info.is_close = 1'b1;
                info.kind     = KIND_PAREN;
            end
            CH_CLOSE_SQUARE: begin
                info.is_close = 1'b1;
                info.kind     = KIND_SQUARE;
            end
            CH_CLOSE_CURLY: begin
                info.is_close = 1'b1;
                info.kind     = KIND_CURLY;
            end
            CH_CLOSE_ANGLE: begin
                info.is_close = 1'b1;
                info.kind     = KIND_ANGLE;
            end
            default: begin
                info = '0;
            end
        endcase
        return info;
    endfunction

    function automatic logic [14:0] closer_weight(input logic [1:0] kind);
        logic [14:0] w;
        case (kind)
            KIND_PAREN:  w = WEIGHT_PAREN;
            KIND_SQUARE: w = WEIGHT_SQUARE;
            KIND_CURLY:  w = WEIGHT_CURLY;
            KIND_ANGLE:  w = WEIGHT_ANGLE;
            default:     w = WEIGHT_PAREN;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/bnc_if.sv */
// Valid/ready channel interfaces of the bracket nesting checker.
// Depends on nothing; payload widths follow the item fields.
interface bnc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       line_end;

    modport source (output valid, output symbol, output line_end, input ready);
    modport sink (input valid, input symbol, input line_end, output ready);
endinterface

interface bnc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  line_kind;
    logic [63:0] score;
    logic [7:0]  open_depth;

    modport source (output valid, output line_kind, output score, output open_depth,
                    input ready);
    modport sink (input valid, input line_kind, input score, input open_depth,
                  output ready);
endinterface

/* hw/rtl/bnc_stack.sv */
// Bracket stack storage: one write port and one read port with registered data.
// No package dependencies.
module bnc_stack #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [1:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [1:0]    o_rd_data
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/bnc_fold.sv */
// Completion score accumulator: score = score*5 + kind + 1, one entry a step.
// Depends on bnc_pkg for the control struct.
module bnc_fold
    import bnc_pkg::*;
(
    input  logic        i_clk,
    input  t_fold_ctl   i_ctl,
    input  logic [1:0]  i_kind,
    output logic [63:0] o_score
);

    logic [63:0] r_score;
    logic [63:0] n_score;

    always_comb begin
        n_score = r_score;
        if (i_ctl.clear) begin
            n_score = '0;
        end else if (i_ctl.step) begin
            n_score = (r_score << 2) + r_score + 64'(i_kind) + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
    end

    assign o_score = r_score;

endmodule

/* hw/rtl/bracket_nesting_checker_unit.sv */
// Bracket nesting checker, top level. Depends on bnc_pkg, bnc_if, bnc_stack, bnc_fold.
// An opener, another character or a closer met while the line is already decided or the
// stack is empty is handled in S_IDLE; a closer checked against the stack adds S_MATCH.
// A line end adds S_FINISH, then one S_FOLD step per open bracket on the score walk of a
// clean line, then S_RESULT, which loads the result register once no earlier result waits.
// Reset clears the sequencer, the count and the line flags; stack contents stay undefined.
module bracket_nesting_checker_unit
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bnc_in_if.sink           i_in,
    bnc_out_if.source        o_out
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state       r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_failed, n_failed;
    logic [14:0]   r_weight, n_weight;
    logic          r_over, n_over;
    logic          r_last, n_last;
    logic [1:0]    r_ck, n_ck;
    logic [AW-1:0] r_idx, n_idx;

    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [63:0]   r_oscore;
    logic [7:0]    r_odepth;

    logic          w_accept;
    logic          w_active;
    logic          w_out_free;
    logic          w_load;
    t_sym_info     w_info;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [1:0]    w_rd_data;
    logic [CW-1:0] w_count_dec;
    t_fold_ctl     w_fold_ctl;
    logic [63:0]   w_fold_score;
    logic [CW+7:0] w_count_wide;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_active    = !r_failed && !r_over;
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_info      = decode_symbol(i_in.symbol);
    assign w_count_dec = r_count - CW'(1);

    bnc_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_info.kind),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bnc_fold u_fold (
        .i_clk   (i_clk),
        .i_ctl   (w_fold_ctl),
        .i_kind  (w_rd_data),
        .o_score (w_fold_score)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_active && w_info.is_close && (r_count != '0)) begin
                        n_state = S_MATCH;
                    end else if (i_in.line_end) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_MATCH: begin
                n_state = r_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (r_failed || r_over || (r_count == '0)) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_idx == '0) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_failed   = r_failed;
        n_weight   = r_weight;
        n_over     = r_over;
        n_last     = r_last;
        n_ck       = r_ck;
        n_idx      = r_idx;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_count[AW-1:0];
        w_rd_en    = 1'b0;
        w_rd_addr  = w_count_dec[AW-1:0];
        w_fold_ctl = '0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_in.line_end;
                    n_ck   = w_info.kind;
                    if (w_active && w_info.is_open) begin
                        if (r_count < CW'(STACK_DEPTH)) begin
                            w_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_over = 1'b1;
                        end
                    end else if (w_active && w_info.is_close) begin
                        if (r_count == '0) begin
                            n_failed = 1'b1;
                            n_weight = closer_weight(w_info.kind);
                        end else begin
                            w_rd_en = 1'b1;
                        end
                    end
                end
            end
            S_MATCH: begin
                if (w_rd_data == r_ck) begin
                    n_count = w_count_dec;
                end else begin
                    n_failed = 1'b1;
                    n_weight = closer_weight(r_ck);
                end
            end
            S_FINISH: begin
                w_fold_ctl.clear = 1'b1;
                if (!r_failed && !r_over && (r_count != '0)) begin
                    w_rd_en = 1'b1;
                    n_idx   = w_count_dec[AW-1:0];
                end
            end
            S_FOLD: begin
                w_fold_ctl.step = 1'b1;
                if (r_idx != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx - AW'(1);
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    n_count  = '0;
                    n_failed = 1'b0;
                    n_weight = '0;
                    n_over   = 1'b0;
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_failed <= 1'b0;
            r_weight <= '0;
            r_over   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_failed <= n_failed;
            r_weight <= n_weight;
            r_over   <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_ck   <= n_ck;
        r_idx  <= n_idx;
    end

    assign w_count_wide = {8'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_failed) begin
                r_okind  <= LK_CORRUPT;
                r_oscore <= 64'(r_weight);
            end else if (r_over) begin
                r_okind  <= LK_OVERFLOW;
                r_oscore <= '0;
            end else begin
                r_okind  <= LK_OPEN;
                r_oscore <= (r_count == '0) ? 64'd0 : w_fold_score;
            end
            r_odepth <= (w_count_wide > (CW + 8)'(255)) ? 8'd255 : w_count_wide[7:0];
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.line_kind  = r_okind;
    assign o_out.score      = r_oscore;
    assign o_out.open_depth = r_odepth;

endmodule

/* hw/rtl/bnc_checker.sv */
// Port-level assertions of the bracket nesting checker and their binding.
// Depends on bnc_pkg and on bracket_nesting_checker_unit.
module bnc_checker
    import bnc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_line_end,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [63:0] i_out_score,
    input logic [7:0]  i_out_depth
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_score))
        else $error("Result item changed or vanished while stalled.");

    a_line_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_line_end |=> !i_in_ready)
        else $error("Input ready straight after a line end item.");

    a_corrupt_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == LK_CORRUPT) |->
            (i_out_score == 64'd3) || (i_out_score == 64'd57) ||
            (i_out_score == 64'd1197) || (i_out_score == 64'd25137))
        else $error("Corrupt line reported with an unknown weight.");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == LK_OVERFLOW) |-> (i_out_score == 64'd0))
        else $error("Overflowed line reported with a non-zero score.");

    a_balanced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == LK_OPEN) && (i_out_depth == 8'd0) |->
            (i_out_score == 64'd0))
        else $error("Balanced line reported with a non-zero score.");

endmodule

bind bracket_nesting_checker_unit bnc_checker u_bnc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_line_end (i_in.line_end),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.line_kind),
    .i_out_score   (o_out.score),
    .i_out_depth   (o_out.open_depth)
);
